// File: hw/rtl/lbc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the LED blink controller.
// No dependencies; the other files of the block, but for lbc_stream_if, refer to it by scoped names.
package lbc_pkg;

    localparam int LED_COUNT_DEF  = 8;
    localparam int ERR_LED_DEF    = 0;
    localparam int SYS_LED_DEF    = 1;
    localparam int YELLOW_LED_DEF = 2;

    // Lines 0..2 form the red/green/yellow group in dual mode.
    localparam logic [7:0] RGY_GROUP = 8'h07;

    localparam logic [15:0] FLASH_PERIOD_RST     = 16'd500;
    localparam logic [15:0] ERROR_PERIOD_RST     = 16'd200;
    localparam logic [3:0]  ERROR_IDLE_STEPS_RST = 4'd4;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [2:0] {
        MODE_ON     = 3'd0,
        MODE_OFF    = 3'd1,
        MODE_INVERT = 3'd2,
        MODE_FLASH  = 3'd3,
        MODE_CODE   = 3'd4,
        MODE_TICK   = 3'd5
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COMBINE_MASK     = 3'd0,
        CFG_FLASH_PERIOD     = 3'd1,
        CFG_ERROR_PERIOD     = 3'd2,
        CFG_ERROR_IDLE_STEPS = 3'd3,
        CFG_DUAL_MODE        = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] led_index;
        logic [3:0] error_code;
    } cmd_t;

    typedef struct packed {
        logic [7:0] led_levels;
        logic [7:0] led_changed;
    } res_t;

    // Handshake status passed from the result register to the command register.
    typedef struct packed {
        logic free;
    } out_status_t;

    // Strobe and command passed from the command register to the state unit.
    typedef struct packed {
        logic advance;
        cmd_t cmd;
    } step_t;

endpackage

// File: hw/rtl/lbc_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel used for the command and result streams.
// The payload type is set per instance from the types in lbc_pkg.
interface lbc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/lbc_cmd_reg.sv
`timescale 1ns / 1ps
// Command register: holds one accepted command until the state unit takes it.
// Depends on lbc_pkg and lbc_stream_if.
module lbc_cmd_reg (
    input  logic                clk,
    input  logic                rst_n,
    lbc_stream_if.sink          cmd,
    input  lbc_pkg::out_status_t status,
    output lbc_pkg::step_t      step
);
    logic         valid_reg;
    logic         valid_next;
    lbc_pkg::cmd_t cmd_reg;
    logic         advance;

    assign advance   = valid_reg && status.free;
    assign cmd.ready = !valid_reg || status.free;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.valid && cmd.ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg <= cmd.payload;
        end
    end

    assign step.advance = advance;
    assign step.cmd     = cmd_reg;
endmodule

// File: hw/rtl/lbc_state.sv
`timescale 1ns / 1ps
// LED marks, driven levels, error pattern and countdowns, plus the register file.
// Depends on lbc_pkg.
module lbc_state #(
    parameter int LED_COUNT  = lbc_pkg::LED_COUNT_DEF,
    parameter int ERR_LED    = lbc_pkg::ERR_LED_DEF,
    parameter int SYS_LED    = lbc_pkg::SYS_LED_DEF,
    parameter int YELLOW_LED = lbc_pkg::YELLOW_LED_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  lbc_pkg::step_t                    step,
    output lbc_pkg::res_t                     result
);
    localparam logic [3:0] LED_COUNT_W = 4'(LED_COUNT);
    localparam logic [7:0] LINE_MASK   = 8'((1 << LED_COUNT) - 1);
    localparam logic [2:0] ERR_IDX     = 3'(ERR_LED);
    localparam logic [2:0] SYS_IDX     = 3'(SYS_LED);
    localparam logic [2:0] YEL_IDX     = 3'(YELLOW_LED);
    localparam logic [7:0] ERR_BIT     = 8'd1 << ERR_IDX;
    localparam logic [7:0] SYS_BIT     = 8'd1 << SYS_IDX;

    logic [7:0]  combine_reg;
    logic [15:0] flash_period_reg;
    logic [15:0] error_period_reg;
    logic [3:0]  idle_steps_reg;
    logic        dual_reg;

    logic [7:0]  on_reg, on_next;
    logic [7:0]  flash_reg, flash_next;
    logic [7:0]  drv_reg, drv_next;
    logic [3:0]  code_reg, code_next;
    logic [5:0]  blink_reg, blink_next;
    logic [15:0] fcd_reg, fcd_next;
    logic [15:0] ecd_reg, ecd_next;

    logic [2:0]  line;
    logic [7:0]  bit_sel;
    logic [7:0]  others;
    logic        yellow;
    logic [5:0]  blink_limit;
    logic [5:0]  blink_inc;
    logic [15:0] flash_reload;
    logic [15:0] error_reload;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            combine_reg      <= '0;
            flash_period_reg <= lbc_pkg::FLASH_PERIOD_RST;
            error_period_reg <= lbc_pkg::ERROR_PERIOD_RST;
            idle_steps_reg   <= lbc_pkg::ERROR_IDLE_STEPS_RST;
            dual_reg         <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lbc_pkg::CFG_COMBINE_MASK:     combine_reg      <= cfg_data[7:0];
                lbc_pkg::CFG_FLASH_PERIOD:     flash_period_reg <= cfg_data;
                lbc_pkg::CFG_ERROR_PERIOD:     error_period_reg <= cfg_data;
                lbc_pkg::CFG_ERROR_IDLE_STEPS: idle_steps_reg   <= cfg_data[3:0];
                lbc_pkg::CFG_DUAL_MODE:        dual_reg         <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // A period of zero behaves as a period of one.
    assign flash_reload = (flash_period_reg == 16'd0) ? 16'd0 : flash_period_reg - 16'd1;
    assign error_reload = (error_period_reg == 16'd0) ? 16'd0 : error_period_reg - 16'd1;

    assign line    = step.cmd.led_index;
    assign bit_sel = 8'd1 << line;
    assign others  = combine_reg & ~bit_sel;
    assign yellow  = dual_reg && (line == YEL_IDX);

    // The pattern ends after the idle steps and 2*code pulse edges.
    assign blink_limit = {2'b00, idle_steps_reg} + {1'b0, code_reg, 1'b0} - 6'd1;
    assign blink_inc   = blink_reg + 6'd1;

    always_comb
    begin
        on_next    = on_reg;
        flash_next = flash_reg;
        drv_next   = drv_reg;
        code_next  = code_reg;
        blink_next = blink_reg;
        fcd_next   = fcd_reg;
        ecd_next   = ecd_reg;

        case (step.cmd.mode) inside
            lbc_pkg::MODE_ON, lbc_pkg::MODE_OFF, lbc_pkg::MODE_INVERT, lbc_pkg::MODE_FLASH:
            begin
                if ({1'b0, line} < LED_COUNT_W)
                begin
                    if (combine_reg[line])
                    begin
                        on_next    = on_next & ~others;
                        flash_next = flash_next & ~others;
                        if (combine_reg[ERR_IDX])
                        begin
                            code_next  = 4'd0;
                            blink_next = 6'd0;
                        end
                    end
                    if (line == ERR_IDX)
                    begin
                        code_next  = 4'd0;
                        blink_next = 6'd0;
                    end
                    if (dual_reg)
                    begin
                        if (step.cmd.mode == lbc_pkg::MODE_ON ||
                            step.cmd.mode == lbc_pkg::MODE_OFF)
                        begin
                            on_next = on_next & ~lbc_pkg::RGY_GROUP;
                        end
                        else
                        begin
                            on_next = on_next & ~(lbc_pkg::RGY_GROUP & ~bit_sel);
                        end
                        flash_next = flash_next & ~lbc_pkg::RGY_GROUP;
                    end
                    case (step.cmd.mode)
                        lbc_pkg::MODE_ON:
                        begin
                            if (yellow)
                            begin
                                on_next = on_next | ERR_BIT | SYS_BIT;
                            end
                            else
                            begin
                                on_next    = on_next | bit_sel;
                                flash_next = flash_next & ~bit_sel;
                            end
                        end
                        lbc_pkg::MODE_OFF:
                        begin
                            if (yellow)
                            begin
                                on_next = on_next & ~(ERR_BIT | SYS_BIT);
                            end
                            else
                            begin
                                on_next    = on_next & ~bit_sel;
                                flash_next = flash_next & ~bit_sel;
                            end
                        end
                        lbc_pkg::MODE_INVERT:
                        begin
                            if (yellow)
                            begin
                                on_next = on_next ^ (ERR_BIT | SYS_BIT);
                            end
                            else
                            begin
                                on_next    = on_next ^ bit_sel;
                                flash_next = flash_next & ~bit_sel;
                            end
                        end
                        default:
                        begin
                            if (yellow)
                            begin
                                flash_next = flash_next | ERR_BIT | SYS_BIT;
                            end
                            else
                            begin
                                on_next    = on_next & ~bit_sel;
                                flash_next = flash_next | bit_sel;
                            end
                        end
                    endcase
                end
            end
            lbc_pkg::MODE_CODE:
            begin
                if (step.cmd.error_code != code_reg)
                begin
                    if (step.cmd.error_code != 4'd0)
                    begin
                        if (combine_reg[ERR_IDX])
                        begin
                            on_next    = on_next & ~(combine_reg & ~ERR_BIT);
                            flash_next = flash_next & ~(combine_reg & ~ERR_BIT);
                        end
                        if (dual_reg)
                        begin
                            on_next    = on_next & ~lbc_pkg::RGY_GROUP;
                            flash_next = flash_next & ~lbc_pkg::RGY_GROUP;
                        end
                        else
                        begin
                            on_next    = on_next & ~ERR_BIT;
                            flash_next = flash_next & ~ERR_BIT;
                        end
                    end
                    code_next  = step.cmd.error_code;
                    blink_next = 6'd0;
                end
            end
            lbc_pkg::MODE_TICK:
            begin
                // Error pattern step first; the countdown holds at zero with no code.
                if (ecd_reg == 16'd0)
                begin
                    if (code_reg != 4'd0)
                    begin
                        ecd_next = error_reload;
                        if (blink_reg < {2'b00, idle_steps_reg})
                        begin
                            on_next = on_next & ~ERR_BIT;
                        end
                        else
                        begin
                            on_next = on_next ^ ERR_BIT;
                        end
                        blink_next = (blink_inc > blink_limit) ? 6'd0 : blink_inc;
                        drv_next   = (drv_next & ~ERR_BIT) | (on_next & ERR_BIT);
                    end
                end
                else
                begin
                    ecd_next = ecd_reg - 16'd1;
                end

                if (fcd_reg == 16'd0)
                begin
                    fcd_next = flash_reload;
                    drv_next = ((drv_next ^ flash_next) & flash_next) | on_next;
                end
                else
                begin
                    fcd_next = fcd_reg - 16'd1;
                end
            end
            default:
            begin
            end
        endcase

        on_next    = on_next & LINE_MASK;
        flash_next = flash_next & LINE_MASK;
        drv_next   = drv_next & LINE_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg    <= '0;
            flash_reg <= SYS_BIT & LINE_MASK;
            drv_reg   <= '0;
            code_reg  <= '0;
            blink_reg <= '0;
            fcd_reg   <= '0;
            ecd_reg   <= '0;
        end
        else if (step.advance)
        begin
            on_reg    <= on_next;
            flash_reg <= flash_next;
            drv_reg   <= drv_next;
            code_reg  <= code_next;
            blink_reg <= blink_next;
            fcd_reg   <= fcd_next;
            ecd_reg   <= ecd_next;
        end
    end

    assign result.led_levels  = drv_next;
    assign result.led_changed = drv_reg ^ drv_next;
endmodule

// File: hw/rtl/lbc_res_reg.sv
`timescale 1ns / 1ps
// Result register: holds one result until the downstream side takes it.
// Depends on lbc_pkg and lbc_stream_if.
module lbc_res_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  lbc_pkg::res_t        result,
    output lbc_pkg::out_status_t status,
    lbc_stream_if.source         res
);
    logic          valid_reg;
    logic          valid_next;
    lbc_pkg::res_t res_reg;

    assign status.free = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign res.valid   = valid_reg;
    assign res.payload = res_reg;
endmodule

// File: hw/rtl/led_blink_controller_top.sv
`timescale 1ns / 1ps
// Top level of the LED blink controller: command register, state unit, result register.
// Depends on lbc_pkg, lbc_stream_if, lbc_cmd_reg, lbc_state and lbc_res_reg.
//
//   Channel  Direction  Handshake      Payload
//   cmd      in         valid/ready    mode, led_index, error_code
//   res      out        valid/ready    led_levels, led_changed
//   cfg      in         cfg_we only    cfg_index, cfg_data (16 bits)
//
// Every command yields exactly one result. A transfer on cmd lands in the command
// register; once the result register has room, the state unit updates all marks, levels
// and countdowns in a single pass and the result register captures the outcome on the
// same edge, so one command per cycle is sustained while res takes every result.
// Reset (rst_n low, asynchronous) restores the register defaults and clears all
// LED state except the flash mark of the system LED.
// A stalled res channel holds its result; cmd keeps taking one more transfer
// into the command register, then stalls until the result is taken.
module led_blink_controller_top #(
    parameter int LED_COUNT  = lbc_pkg::LED_COUNT_DEF,
    parameter int ERR_LED    = lbc_pkg::ERR_LED_DEF,
    parameter int SYS_LED    = lbc_pkg::SYS_LED_DEF,
    parameter int YELLOW_LED = lbc_pkg::YELLOW_LED_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lbc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]  cfg_data,
    lbc_stream_if.sink                      cmd,
    lbc_stream_if.source                    res
);
    // Free slot in the result register, fed back to the command register.
    lbc_pkg::out_status_t status;
    // Command handed to the state unit and the strobe that commits it.
    lbc_pkg::step_t       step;
    // Combinational outcome of the committed command.
    lbc_pkg::res_t        result;

    lbc_cmd_reg u_cmd_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .step   (step)
    );

    lbc_state #(
        .LED_COUNT  (LED_COUNT),
        .ERR_LED    (ERR_LED),
        .SYS_LED    (SYS_LED),
        .YELLOW_LED (YELLOW_LED)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .result    (result)
    );

    // The result register loads on the same edge that commits the state update.
    lbc_res_reg u_res_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (step.advance),
        .result (result),
        .status (status),
        .res    (res)
    );
endmodule

// File: tb/tb_led_blink_controller_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_blink_controller_top: drives commands, ticks and register
// settings, predicts every LED result in SystemVerilog and checks it. Needs lbc_pkg,
// lbc_stream_if and the RTL of the block.
module tb_led_blink_controller_top;

    // Block geometry, taken from the package defaults that the instance uses.
    localparam int         LED_LINES   = lbc_pkg::LED_COUNT_DEF;
    localparam int         ERR_LINE    = lbc_pkg::ERR_LED_DEF;
    localparam int         SYS_LINE    = lbc_pkg::SYS_LED_DEF;
    localparam int         YELLOW_LINE = lbc_pkg::YELLOW_LED_DEF;
    localparam logic [7:0] ERR_BIT     = 8'd1 << ERR_LINE;
    localparam logic [7:0] SYS_BIT     = 8'd1 << SYS_LINE;
    localparam logic [7:0] LINE_MASK   = 8'hFF >> (8 - LED_LINES);

    // Modes 6 and 7 have no meaning; the block must leave everything as it is.
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    // The longest honest silence on both channels is the long result hold plus a long
    // sender gap plus a register update; this is many times that.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 80;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        lbc_pkg::cmd_t cmd;
        logic          typed;
        lbc_pkg::res_t want;
    } opening_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [lbc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lbc_pkg::CFG_DATA_W-1:0]  cfg_data;

    lbc_stream_if #(.payload_t(lbc_pkg::cmd_t)) cmd_if ();
    lbc_stream_if #(.payload_t(lbc_pkg::res_t)) res_if ();

    led_blink_controller_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .res       (res_if)
    );

    // Predictor copy of the registers.
    logic [7:0]  grp_mask;
    logic [15:0] flash_len;
    logic [15:0] err_len;
    logic [3:0]  dark_steps;
    logic        rgy_mode;

    // Predictor copy of the LED state.
    logic [7:0]  on_lines;
    logic [7:0]  flash_lines;
    logic [7:0]  lit_lines;
    logic [3:0]  blink_code;
    logic [5:0]  pattern_pos;
    logic [15:0] flash_cnt;
    logic [15:0] err_cnt;

    // Expected LED results, oldest first, and the bookkeeping around them.
    lbc_pkg::res_t expected_leds[$];
    opening_row_t  opening_rows[$];
    int            failures;
    int            items_done;
    int            quiet_cycles;

    // Knobs that the main sequence turns between phases.
    logic src_quiet;
    logic snk_quiet;
    logic hold_req;

    // The directed rows carry an optional typed expectation alongside the payload, so
    // the monitor can tell which value to queue when the transfer happens.
    logic          row_typed;
    lbc_pkg::res_t row_want;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void leds_reset();
        grp_mask    = 8'h00;
        flash_len   = lbc_pkg::FLASH_PERIOD_RST;
        err_len     = lbc_pkg::ERROR_PERIOD_RST;
        dark_steps  = lbc_pkg::ERROR_IDLE_STEPS_RST;
        rgy_mode    = 1'b0;
        on_lines    = 8'h00;
        flash_lines = SYS_BIT & LINE_MASK;
        lit_lines   = 8'h00;
        blink_code  = 4'd0;
        pattern_pos = 6'd0;
        flash_cnt   = 16'd0;
        err_cnt     = 16'd0;
    endfunction

    function automatic void set_register(input lbc_pkg::cfg_index_t idx,
                                         input logic [15:0] val);
        case (idx)
            lbc_pkg::CFG_COMBINE_MASK:     grp_mask = val[7:0];
            lbc_pkg::CFG_FLASH_PERIOD:     flash_len = val;
            lbc_pkg::CFG_ERROR_PERIOD:     err_len = val;
            lbc_pkg::CFG_ERROR_IDLE_STEPS: dark_steps = val[3:0];
            lbc_pkg::CFG_DUAL_MODE:        rgy_mode = val[0];
            default:                       ;
        endcase
    endfunction

    // Stopping the error pattern only restarts it if a code was active.
    function automatic void stop_code();
        if (blink_code != 4'd0)
        begin
            blink_code  = 4'd0;
            pattern_pos = 6'd0;
        end
    endfunction

    // A command on a grouped line clears the marks of its group partners; when the
    // error line is part of the group, the error pattern stops too.
    function automatic void release_group(input int line);
        logic [7:0] sel;
        logic [7:0] others;
        sel = 8'd1 << line;
        if ((grp_mask & sel) != 8'h00)
        begin
            others = grp_mask & ~sel;
            on_lines    &= ~others;
            flash_lines &= ~others;
            if ((grp_mask & ERR_BIT) != 8'h00)
                stop_code();
        end
    endfunction

    function automatic void start_code(input logic [3:0] code);
        if (code != blink_code)
        begin
            if (code != 4'd0)
            begin
                release_group(ERR_LINE);
                if (rgy_mode)
                begin
                    on_lines    &= ~lbc_pkg::RGY_GROUP;
                    flash_lines &= ~lbc_pkg::RGY_GROUP;
                end
                else
                begin
                    on_lines    &= ~ERR_BIT;
                    flash_lines &= ~ERR_BIT;
                end
            end
            blink_code  = code;
            pattern_pos = 6'd0;
        end
    endfunction

    function automatic void drive_line(input logic [2:0] mode, input int line);
        logic [7:0] sel;
        logic       yellow;
        sel    = 8'd1 << line;
        yellow = rgy_mode && (line == YELLOW_LINE);
        release_group(line);
        if (line == ERR_LINE)
            stop_code();
        if (rgy_mode)
        begin
            if (mode == lbc_pkg::MODE_ON || mode == lbc_pkg::MODE_OFF)
                on_lines &= ~lbc_pkg::RGY_GROUP;
            else
                on_lines &= ~(lbc_pkg::RGY_GROUP & ~sel);
            flash_lines &= ~lbc_pkg::RGY_GROUP;
        end
        // In dual mode yellow is shown as red plus green.
        case (mode)
            lbc_pkg::MODE_ON:
                if (yellow)
                    on_lines |= ERR_BIT | SYS_BIT;
                else
                begin
                    on_lines    |= sel;
                    flash_lines &= ~sel;
                end
            lbc_pkg::MODE_OFF:
                if (yellow)
                    on_lines &= ~(ERR_BIT | SYS_BIT);
                else
                begin
                    on_lines    &= ~sel;
                    flash_lines &= ~sel;
                end
            lbc_pkg::MODE_INVERT:
                if (yellow)
                    on_lines ^= ERR_BIT | SYS_BIT;
                else
                begin
                    on_lines    ^= sel;
                    flash_lines &= ~sel;
                end
            default:
                if (yellow)
                    flash_lines |= ERR_BIT | SYS_BIT;
                else
                begin
                    on_lines    &= ~sel;
                    flash_lines |= sel;
                end
        endcase
    endfunction

    // One time tick: the error countdown steps first, then the flash countdown.
    // A countdown at zero fires and reloads with period-1; a zero period acts as one.
    // The error countdown parks at zero while no code is active.
    function automatic void tick_once();
        logic fire;
        int   last_pos;
        fire = 1'b0;
        if (err_cnt == 16'd0)
        begin
            if (blink_code != 4'd0)
            begin
                err_cnt = ((err_len == 16'd0) ? 16'd1 : err_len) - 16'd1;
                fire    = 1'b1;
            end
        end
        else
            err_cnt = err_cnt - 16'd1;

        if (fire)
        begin
            if (pattern_pos < dark_steps)
                on_lines &= ~ERR_BIT;
            else
                on_lines ^= ERR_BIT;
            pattern_pos = pattern_pos + 6'd1;
            last_pos = int'(dark_steps) + 1 + 2 * (int'(blink_code) - 1);
            if (int'(pattern_pos) > last_pos)
                pattern_pos = 6'd0;
            lit_lines = (lit_lines & ~ERR_BIT) | (on_lines & ERR_BIT);
        end

        if (flash_cnt == 16'd0)
        begin
            flash_cnt = ((flash_len == 16'd0) ? 16'd1 : flash_len) - 16'd1;
            lit_lines = ((lit_lines ^ flash_lines) & flash_lines) | on_lines;
        end
        else
            flash_cnt = flash_cnt - 16'd1;
    endfunction

    // Applies one command to the predicted state and returns the LED result it causes.
    function automatic lbc_pkg::res_t led_step(input lbc_pkg::cmd_t c);
        logic [7:0]    prior;
        lbc_pkg::res_t r;
        prior = lit_lines;
        if (c.mode == lbc_pkg::MODE_ON || c.mode == lbc_pkg::MODE_OFF
            || c.mode == lbc_pkg::MODE_INVERT || c.mode == lbc_pkg::MODE_FLASH)
        begin
            if (int'(c.led_index) < LED_LINES)
                drive_line(c.mode, int'(c.led_index));
        end
        else if (c.mode == lbc_pkg::MODE_CODE)
            start_code(c.error_code);
        else if (c.mode == lbc_pkg::MODE_TICK)
            tick_once();
        on_lines    &= LINE_MASK;
        flash_lines &= LINE_MASK;
        lit_lines   &= LINE_MASK;
        r.led_levels  = lit_lines;
        r.led_changed = prior ^ lit_lines;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_failure(input string what, input logic [7:0] want,
                                input logic [7:0] got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("ERROR at %0t: %s expected %02h got %02h", $realtime, what, want, got);
    endtask

    // The monitor samples both channels at the rising edge, the same instant the block
    // does, so a transfer is seen exactly when the block sees it.
    always @(posedge clk)
    begin : check_block
        lbc_pkg::res_t want;
        lbc_pkg::res_t got;
        if (rst_n)
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                want = led_step(cmd_if.payload);
                if (row_typed)
                    want = row_want;
                expected_leds.push_back(want);
            end
            if (res_if.valid && res_if.ready)
            begin
                got = res_if.payload;
                if (expected_leds.size() == 0)
                    note_failure("unexpected result, levels", 8'h00, got.led_levels);
                else
                begin
                    want = expected_leds.pop_front();
                    if (got.led_levels !== want.led_levels)
                        note_failure("led_levels", want.led_levels, got.led_levels);
                    if (got.led_changed !== want.led_changed)
                        note_failure("led_changed", want.led_changed, got.led_changed);
                end
            end
        end
    end

    // The watchdog only counts cycles in which neither channel moves a transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("led_blink_controller_top: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, plus one long hold on request
    // ------------------------------------------------------------------

    // Most gaps are short; now and then one is long.
    function automatic int pick_gap();
        if ($urandom_range(99) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    initial
    begin : sink_block
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // The long hold is counted here, in the receiver itself, so the sender
                // keeps offering commands until the block stops taking them.
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (!rst_n)
                res_if.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (!snk_quiet && $urandom_range(99) < 25)
            begin
                res_if.ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Offers one command and returns at the edge where it is transferred. It is always
    // entered at a rising edge, so valid receives a single update per edge.
    task automatic send_cmd(input lbc_pkg::cmd_t c, input logic typed,
                            input lbc_pkg::res_t want);
        int gap;
        gap = 0;
        if (!src_quiet && $urandom_range(99) < 30)
            gap = pick_gap();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= c;
        row_typed      <= typed;
        row_want       <= want;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        if (c.mode != MODE_SPARE_A && c.mode != MODE_SPARE_B)
            items_done++;
    endtask

    task automatic send_plain(input lbc_pkg::cmd_t c);
        send_cmd(c, 1'b0, '0);
    endtask

    // Lowers valid and waits until every queued result has come back. Checked at the
    // falling edge, after all rising-edge updates have settled.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_leds.size() != 0);
        // Every command yields one result, so nothing is left inside the block now.
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input lbc_pkg::cfg_index_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        set_register(idx, val);
        @(posedge clk);
    endtask

    // Registers change only while the block is empty.
    task automatic load_setting(input logic [7:0] mask, input logic [15:0] flash_ticks,
                                input logic [15:0] err_ticks, input logic [3:0] idle,
                                input logic dual);
        wait_drained();
        write_register(lbc_pkg::CFG_COMBINE_MASK, {8'h00, mask});
        write_register(lbc_pkg::CFG_FLASH_PERIOD, flash_ticks);
        write_register(lbc_pkg::CFG_ERROR_PERIOD, err_ticks);
        write_register(lbc_pkg::CFG_ERROR_IDLE_STEPS, {12'h000, idle});
        write_register(lbc_pkg::CFG_DUAL_MODE, {15'h0000, dual});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic lbc_pkg::cmd_t random_cmd();
        lbc_pkg::cmd_t c;
        int            pick;
        c.led_index  = 3'($urandom_range(7));
        c.error_code = 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 40)
            c.mode = lbc_pkg::MODE_TICK;
        else if (pick < 50)
            c.mode = lbc_pkg::MODE_ON;
        else if (pick < 60)
            c.mode = lbc_pkg::MODE_OFF;
        else if (pick < 70)
            c.mode = lbc_pkg::MODE_INVERT;
        else if (pick < 80)
            c.mode = lbc_pkg::MODE_FLASH;
        else if (pick < 94)
            c.mode = lbc_pkg::MODE_CODE;
        else if (pick < 97)
            c.mode = MODE_SPARE_A;
        else
            c.mode = MODE_SPARE_B;
        return c;
    endfunction

    // Random traffic. The error pattern only gets past its dark steps when a code
    // stays in place over many ticks, so part of the stimulus is a code followed by
    // a run of ticks; the rest is free mixing of every mode.
    task automatic run_random(input int count);
        int            stop_at;
        int            ticks;
        lbc_pkg::cmd_t c;
        stop_at = items_done + count;
        while (items_done < stop_at)
        begin
            if ($urandom_range(99) < 8)
            begin
                c = random_cmd();
                c.mode       = lbc_pkg::MODE_CODE;
                c.error_code = 4'($urandom_range(15, 1));
                send_plain(c);
                ticks = $urandom_range(50, 10);
                repeat (ticks)
                begin
                    c = random_cmd();
                    c.mode = lbc_pkg::MODE_TICK;
                    send_plain(c);
                end
            end
            else
                send_plain(random_cmd());
        end
    endtask

    task automatic add_row(input logic [2:0] mode, input logic [2:0] line,
                           input logic [3:0] code, input logic typed,
                           input logic [7:0] levels, input logic [7:0] changed);
        opening_row_t r;
        r.cmd.mode         = mode;
        r.cmd.led_index    = line;
        r.cmd.error_code   = code;
        r.typed            = typed;
        r.want.led_levels  = levels;
        r.want.led_changed = changed;
        opening_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_block
        lbc_pkg::res_t leftover;
        lbc_pkg::cmd_t c;

        failures       = 0;
        items_done     = 0;
        quiet_cycles   = 0;
        src_quiet      = 1'b0;
        snk_quiet      = 1'b0;
        hold_req       = 1'b0;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= lbc_pkg::CFG_COMBINE_MASK;
        cfg_data       <= '0;
        cmd_if.valid   <= 1'b0;
        cmd_if.payload <= '0;
        row_typed      <= 1'b0;
        row_want       <= '0;
        leds_reset();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset settings. The first tick fires the flash
        // countdown and lights the system LED, which is the only flashing line after
        // reset. Commands other than ticks never move the driven levels, so until the
        // next tick every result reads back the same levels with nothing changed.
        add_row(lbc_pkg::MODE_TICK,   3'd0, 4'd0,  1'b1, 8'h02, 8'h02);
        add_row(lbc_pkg::MODE_ON,     3'd7, 4'd0,  1'b1, 8'h02, 8'h00);
        add_row(lbc_pkg::MODE_OFF,    3'd7, 4'd15, 1'b1, 8'h02, 8'h00);
        add_row(lbc_pkg::MODE_INVERT, 3'd3, 4'd5,  1'b1, 8'h02, 8'h00);
        add_row(lbc_pkg::MODE_FLASH,  3'd5, 4'd10, 1'b1, 8'h02, 8'h00);
        add_row(MODE_SPARE_A,         3'd4, 4'd9,  1'b1, 8'h02, 8'h00);
        add_row(MODE_SPARE_B,         3'd7, 4'd15, 1'b1, 8'h02, 8'h00);
        add_row(lbc_pkg::MODE_CODE,   3'd0, 4'd15, 1'b1, 8'h02, 8'h00);
        // Setting the code that is already active changes nothing.
        add_row(lbc_pkg::MODE_CODE,   3'd2, 4'd15, 1'b1, 8'h02, 8'h00);
        // From here on the predictor supplies the expectation.
        add_row(lbc_pkg::MODE_TICK,   3'd0, 4'd0,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_CODE,   3'd0, 4'd0,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_CODE,   3'd0, 4'd1,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_TICK,   3'd7, 4'd15, 1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_ON,     3'd0, 4'd0,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_FLASH,  3'd2, 4'd0,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_INVERT, 3'd1, 4'd0,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_OFF,    3'd1, 4'd0,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_ON,     3'd6, 4'd0,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_INVERT, 3'd6, 4'd0,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_FLASH,  3'd0, 4'd0,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_CODE,   3'd5, 4'd8,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_TICK,   3'd5, 4'd8,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_TICK,   3'd2, 4'd7,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_OFF,    3'd3, 4'd0,  1'b0, 8'h00, 8'h00);
        add_row(lbc_pkg::MODE_FLASH,  3'd7, 4'd0,  1'b0, 8'h00, 8'h00);
        foreach (opening_rows[i])
            send_cmd(opening_rows[i].cmd, opening_rows[i].typed, opening_rows[i].want);

        // Random traffic at the reset settings.
        run_random(60);

        // Shortest periods, no grouping, one dark step, and no idling on either side.
        load_setting(8'h00, 16'd1, 16'd1, 4'd1, 1'b0);
        src_quiet = 1'b1;
        snk_quiet = 1'b1;
        run_random(90);
        src_quiet = 1'b0;
        snk_quiet = 1'b0;

        // Zero periods act as one; all lines grouped; longest dark phase; dual mode.
        load_setting(8'hFF, 16'd0, 16'd0, 4'd15, 1'b1);
        run_random(90);

        // Dual mode with random grouping and no dark steps. Partway through, the
        // result side holds off for a long stretch while the sender keeps offering
        // commands back to back, so the block fills up and stalls its input.
        load_setting(8'($urandom_range(255)), 16'($urandom_range(6, 2)),
                     16'($urandom_range(3, 1)), 4'd0, 1'b1);
        run_random(30);
        cmd_if.valid <= 1'b0;
        @(negedge clk);
        hold_req = 1'b1;
        src_quiet = 1'b1;
        @(posedge clk);
        run_random(60);
        src_quiet = 1'b0;

        // Longest periods: the countdowns fire once and then hardly move.
        load_setting(lbc_pkg::RGY_GROUP, 16'hFFFF, 16'hFFFF, 4'($urandom_range(15, 1)),
                     1'b0);
        run_random(90);

        // Random short settings; halfway the sender stops until every result is back.
        load_setting(8'($urandom_range(255)), 16'($urandom_range(4, 1)),
                     16'($urandom_range(4, 1)), 4'($urandom_range(15)),
                     1'($urandom_range(1)));
        run_random(45);
        wait_drained();
        run_random(45);

        // Only the error line is grouped, so a command on it stops the error pattern.
        load_setting(ERR_BIT, 16'd3, 16'd2, 4'd3, 1'b0);
        run_random(90);

        // Fully random settings with small periods.
        load_setting(8'($urandom_range(255)), 16'($urandom_range(8, 1)),
                     16'($urandom_range(8, 1)), 4'($urandom_range(15)),
                     1'($urandom_range(1)));
        run_random(90);

        // Drain, let the clock run on, then judge the run.
        wait_drained();
        repeat (10) @(posedge clk);
        while (expected_leds.size() != 0)
        begin
            leftover = expected_leds.pop_front();
            note_failure("missing result, levels", leftover.led_levels, 8'h00);
        end
        if (failures == 0)
            $display("led_blink_controller_top: match");
        else
            $display("led_blink_controller_top: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/lbc_pkg.sv
hw/rtl/lbc_stream_if.sv
hw/rtl/lbc_cmd_reg.sv
hw/rtl/lbc_state.sv
hw/rtl/lbc_res_reg.sv
hw/rtl/led_blink_controller_top.sv
tb/tb_led_blink_controller_top.sv
